@@ design/cwwf_pkg.sv @@
`default_nettype none

package cwwf_pkg;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WRAP,
        S_BRK_CR,
        S_BRK_LF,
        S_RD,
        S_OUT,
        S_COLUPD,
        S_SPACE,
        S_SP_INC,
        S_EMIT,
        S_EMIT2,
        S_STORE
    } t_state;

    // Request to the shared add and compare unit.
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_alu_req;

    // Response of the shared add and compare unit.
    typedef struct packed {
        logic [8:0] sum;
        logic [7:0] sat;
        logic       gt;
        logic       ge;
    } t_alu_rsp;

    // Configuration register indexes.
    localparam logic [7:0] CFG_IDX_TERM_WIDTH = 8'd0;
    localparam logic [7:0] CFG_IDX_DISCARD    = 8'd1;

    localparam logic [7:0] TERM_WIDTH_RST = 8'd110;

    // Escape phases.
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_CSI      = 8'h5B;
    localparam logic [7:0] ESC_FINAL_LO = 8'h40;
    localparam logic [7:0] ESC_FINAL_HI = 8'h7E;
    localparam logic [1:0] UTF8_CONT_TAG = 2'b10;

endpackage

`default_nettype wire

@@ design/cwwf_alu.sv @@
`default_nettype none

module cwwf_alu (
    input  wire  cwwf_pkg::t_alu_req i_req,
    output cwwf_pkg::t_alu_rsp       o_rsp
);
    import cwwf_pkg::*;

    logic [8:0] sum;

    // One adder with a compare of its sum against a limit.
    assign sum        = {1'b0, i_req.a} + {1'b0, i_req.b};
    assign o_rsp.sum  = sum;
    assign o_rsp.sat  = sum[8] ? 8'hFF : sum[7:0];
    assign o_rsp.gt   = sum > {1'b0, i_req.c};
    assign o_rsp.ge   = sum >= {1'b0, i_req.c};

endmodule

`default_nettype wire

@@ design/cwwf_word_buf.sv @@
`default_nettype none

module cwwf_word_buf #(
    parameter int DEPTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire  [7:0]                i_wr_data,
    input  wire  [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [7:0]                o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/cwwf_seq.sv @@
`default_nettype none

module cwwf_seq #(
    parameter int WORD_BUF_BYTES = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [7:0]                        i_in_byte,
    input  wire                               i_in_eoc,
    input  wire  [7:0]                        i_term_width,
    input  wire                               i_discard,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [7:0]                        o_out_byte,
    output logic                              o_out_last,
    output cwwf_pkg::t_alu_req                o_alu_req,
    input  wire  cwwf_pkg::t_alu_rsp          i_alu_rsp,
    output logic                              o_mem_we,
    output logic [$clog2(WORD_BUF_BYTES)-1:0] o_mem_waddr,
    output logic [7:0]                        o_mem_wdata,
    output logic [$clog2(WORD_BUF_BYTES)-1:0] o_mem_raddr,
    input  wire  [7:0]                        i_mem_rdata
);
    import cwwf_pkg::*;

    localparam int AW = $clog2(WORD_BUF_BYTES);
    localparam logic [AW-1:0] CNT_FULL = AW'(WORD_BUF_BYTES - 1);

    t_state        r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_col, n_col;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_wcc, n_wcc;
    logic [AW-1:0] r_idx, n_idx;
    logic [7:0]    r_byte, n_byte;
    logic          r_eoc, n_eoc;
    logic [7:0]    r_emit_byte, n_emit_byte;
    logic          r_in_post, n_in_post;
    logic          r_do_emit, n_do_emit;
    logic          r_is_space, n_is_space;
    logic          r_do_store, n_do_store;
    logic          r_is_eol, n_is_eol;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic          accept;
    logic          slot_free;
    logic          emit_vld;
    logic [7:0]    emit_byte;
    logic          emit_last;

    logic          dec_esc_act, dec_is_esc, dec_is_eol, dec_is_space, dec_store;
    logic          dec_cont, dec_pre, dec_emit, dec_final;
    logic          out_final, out_last;

    function automatic t_state after_send(input logic sp, input logic em, input logic st);
        t_state s;
        if (sp) begin
            s = S_SPACE;
        end else if (em) begin
            s = S_EMIT;
        end else if (st) begin
            s = S_STORE;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    // Classification of the held byte.
    assign dec_esc_act  = (r_phase != PH_NONE);
    assign dec_is_esc   = (r_byte == CH_ESC);
    assign dec_is_eol   = (r_byte == CH_LF) || (r_byte == CH_CR);
    assign dec_is_space = (r_byte == CH_SPACE);
    assign dec_cont     = (r_byte[7:6] == UTF8_CONT_TAG);
    assign dec_store    = !dec_esc_act && !dec_is_esc && !dec_is_eol && !dec_is_space;
    assign dec_emit     = dec_esc_act || dec_is_esc || dec_is_eol;
    assign dec_pre      = !dec_esc_act && (dec_is_esc || dec_is_eol || dec_is_space
                          || (dec_store && ((!dec_cont && i_alu_rsp.ge)
                          || (r_count >= CNT_FULL))));
    assign dec_final    = (r_byte >= ESC_FINAL_LO) && (r_byte <= ESC_FINAL_HI);

    // A word byte is the last of the run only if nothing follows the word.
    assign out_final = i_alu_rsp.ge;
    assign out_last  = out_final && (r_in_post
                       || !(r_do_emit || r_is_space || (r_do_store && r_eoc)));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_discard) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (dec_esc_act) begin
                    n_state = S_EMIT;
                end else if (dec_pre && (r_count != '0)) begin
                    n_state = S_WRAP;
                end else begin
                    n_state = after_send(dec_is_space, dec_emit, dec_store);
                end
            end
            S_WRAP: begin
                if ((r_col != 8'd0) && i_alu_rsp.gt) begin
                    n_state = S_BRK_CR;
                end else begin
                    n_state = S_RD;
                end
            end
            S_BRK_CR: begin
                if (slot_free) begin
                    n_state = S_BRK_LF;
                end
            end
            S_BRK_LF: begin
                if (slot_free) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_state = out_final ? S_COLUPD : S_RD;
                end
            end
            S_COLUPD: begin
                if (r_in_post) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = after_send(r_is_space, r_do_emit, r_do_store);
                end
            end
            S_SPACE: begin
                n_state = i_alu_rsp.ge ? S_EMIT : S_SP_INC;
            end
            S_SP_INC: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = (r_emit_byte == CH_LF) ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_STORE: begin
                n_state = r_eoc ? S_WRAP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, shared unit operands and emitted bytes.
    always_comb begin
        o_alu_req   = '{a: r_col, b: 8'd0, c: i_term_width};
        emit_vld    = 1'b0;
        emit_byte   = r_emit_byte;
        emit_last   = 1'b0;
        o_mem_we    = 1'b0;
        n_phase     = r_phase;
        n_col       = r_col;
        n_count     = r_count;
        n_wcc       = r_wcc;
        n_idx       = r_idx;
        n_byte      = r_byte;
        n_eoc       = r_eoc;
        n_emit_byte = r_emit_byte;
        n_in_post   = r_in_post;
        n_do_emit   = r_do_emit;
        n_is_space  = r_is_space;
        n_do_store  = r_do_store;
        n_is_eol    = r_is_eol;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_byte = i_in_byte;
                    n_eoc  = i_in_eoc;
                end
            end
            S_DECODE: begin
                o_alu_req.a = {{(8-AW){1'b0}}, r_wcc};
                n_emit_byte = r_byte;
                n_in_post   = 1'b0;
                n_do_emit   = dec_emit;
                n_is_space  = dec_is_space;
                n_do_store  = dec_store;
                n_is_eol    = dec_is_eol && !dec_esc_act;
                if (dec_esc_act) begin
                    if ((r_phase == PH_ESC) && (r_byte == CH_CSI)) begin
                        n_phase = PH_CSI;
                    end else if (dec_final) begin
                        n_phase = PH_NONE;
                    end
                end else if (dec_is_esc) begin
                    n_phase = PH_ESC;
                end
            end
            S_WRAP: begin
                o_alu_req.b = {{(8-AW){1'b0}}, r_wcc};
            end
            S_BRK_CR: begin
                emit_vld  = 1'b1;
                emit_byte = CH_CR;
            end
            S_BRK_LF: begin
                emit_vld  = 1'b1;
                emit_byte = CH_LF;
                if (slot_free) begin
                    n_col = 8'd0;
                end
            end
            S_OUT: begin
                o_alu_req.a = {{(8-AW){1'b0}}, r_idx};
                o_alu_req.b = 8'd1;
                o_alu_req.c = {{(8-AW){1'b0}}, r_count};
                emit_vld    = 1'b1;
                emit_byte   = i_mem_rdata;
                emit_last   = out_last;
                if (slot_free) begin
                    n_idx = i_alu_rsp.sum[AW-1:0];
                end
            end
            S_COLUPD: begin
                o_alu_req.b = {{(8-AW){1'b0}}, r_wcc};
                n_col   = i_alu_rsp.sat;
                n_count = '0;
                n_wcc   = '0;
                n_idx   = '0;
            end
            S_SPACE: begin
                if (i_alu_rsp.ge) begin
                    n_emit_byte = CH_LF;
                    n_col       = 8'd0;
                end else begin
                    n_emit_byte = CH_SPACE;
                end
            end
            S_SP_INC: begin
                o_alu_req.b = 8'd1;
                n_col       = i_alu_rsp.sat;
            end
            S_EMIT: begin
                emit_vld = 1'b1;
                if (r_emit_byte == CH_LF) begin
                    emit_byte = CH_CR;
                end else begin
                    emit_last = 1'b1;
                    if (slot_free && r_is_eol) begin
                        n_col = 8'd0;
                    end
                end
            end
            S_EMIT2: begin
                emit_vld  = 1'b1;
                emit_byte = CH_LF;
                emit_last = 1'b1;
                if (slot_free && r_is_eol) begin
                    n_col = 8'd0;
                end
            end
            S_STORE: begin
                o_alu_req.a = {{(8-AW){1'b0}}, r_wcc};
                o_alu_req.b = {7'd0, !dec_cont};
                o_mem_we    = 1'b1;
                n_wcc       = i_alu_rsp.sum[AW-1:0];
                n_count     = r_count + AW'(1);
                n_in_post   = r_eoc;
            end
            default: begin
            end
        endcase
    end

    assign o_mem_waddr = r_count;
    assign o_mem_wdata = r_byte;
    assign o_mem_raddr = r_idx;

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_NONE;
            r_col      <= 8'd0;
            r_count    <= '0;
            r_wcc      <= '0;
            r_idx      <= '0;
            r_in_post  <= 1'b0;
            r_do_emit  <= 1'b0;
            r_is_space <= 1'b0;
            r_do_store <= 1'b0;
            r_is_eol   <= 1'b0;
            r_eoc      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_col      <= n_col;
            r_count    <= n_count;
            r_wcc      <= n_wcc;
            r_idx      <= n_idx;
            r_in_post  <= n_in_post;
            r_do_emit  <= n_do_emit;
            r_is_space <= n_is_space;
            r_do_store <= n_do_store;
            r_is_eol   <= n_is_eol;
            r_eoc      <= n_eoc;
        end
        r_byte      <= n_byte;
        r_emit_byte <= n_emit_byte;
    end

    // Output register; the sequencer waits while it holds an untaken request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= emit_vld;
        end
        if (slot_free && emit_vld) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

@@ design/console_word_wrap_formatter.sv @@
// Console word-wrap formatter.
// Text bytes arrive on the slave stream (tdata = byte, tlast = end of call)
// and formatted bytes leave on the master stream (tdata = byte, tlast marks
// the final byte caused by one input request). Words are held in a buffer
// and sent with a line break in front when they would pass the terminal
// width; every LF goes out as CR LF and escape sequences pass unchanged.
// Configuration: index 0 is the terminal width, index 1 the discard flag;
// the configuration channel is always ready.
// Handling of a request: it is accepted and decoded, and then a word byte is
// stored in the buffer, a CR or an escape byte is passed on, an LF is sent as
// CR LF and a space is sent or turned into a line break. Sending a held word
// makes the wrap check, sends a line break first when the word would overrun,
// then reads each word byte from the registered buffer and outputs it while
// the shared add and compare unit steps the read index, and updates the column.
// The slave side is not ready while a request is in progress; a discarded
// request is accepted and dropped without being decoded.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits. Reset clears the escape phase, the cursor column and
// the word counts; no clearing pass is made over the buffer.
`default_nettype none

module console_word_wrap_formatter #(
    parameter int WORD_BUF_BYTES = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire  [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire        i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [7:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data
);
    import cwwf_pkg::*;

    localparam int AW = $clog2(WORD_BUF_BYTES);

    logic [7:0]    r_term_width;
    logic          r_discard;
    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_width <= TERM_WIDTH_RST;
            r_discard    <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_TERM_WIDTH) begin
                r_term_width <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_DISCARD) begin
                r_discard <= i_cfg_data[0];
            end
        end
    end

    cwwf_seq #(
        .WORD_BUF_BYTES(WORD_BUF_BYTES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_byte    (i_s_axis_tdata),
        .i_in_eoc     (i_s_axis_tlast),
        .i_term_width (r_term_width),
        .i_discard    (r_discard),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_byte   (o_m_axis_tdata),
        .o_out_last   (o_m_axis_tlast),
        .o_alu_req    (alu_req),
        .i_alu_rsp    (alu_rsp),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    cwwf_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    cwwf_word_buf #(
        .DEPTH(WORD_BUF_BYTES)
    ) u_word_buf (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

endmodule

`default_nettype wire

@@ tb/wrap_output_checker.sv @@
`timescale 1ns / 100ps

// Watches the text, output and configuration channels of the word-wrap
// formatter. It predicts the output bytes of every accepted request and
// compares each delivered byte with the oldest prediction.
module wrap_output_checker #(
    parameter int WORD_BUF_BYTES = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_req_valid,
    input  wire        i_req_ready,
    input  wire  [7:0] i_req_data,    // [7:0] in_byte
    input  wire        i_req_last,    // end_of_call
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  wire  [7:0] i_out_data,    // [7:0] out_byte
    input  wire        i_out_last,    // last_of_run
    input  wire        i_cfg_valid,
    input  wire        i_cfg_ready,
    input  wire  [7:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data,
    output int         o_pending,
    output int         o_errors,
    output int         o_checked
);
    import cwwf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_tx_byte;

    // Output bytes still owed by the block, oldest first.
    t_tx_byte    due_bytes[$];
    t_tx_byte    held;
    logic        have_held;

    // Shadow copy of the configuration and of the formatter state.
    logic [7:0]  width_cfg;
    logic        discard_cfg;
    logic [1:0]  esc_phase;
    int unsigned column;
    logic [7:0]  word_buf [WORD_BUF_BYTES];
    int unsigned word_nbytes;
    int unsigned word_cols;

    int          err_count = 0;
    int          ok_count = 0;

    // The newest byte of a request is held back so that it can be marked
    // as the last one once the request is fully handled.
    function automatic void emit_raw(input logic [7:0] b);
        if (have_held)
            due_bytes.push_back(held);
        held.data = b;
        held.last = 1'b0;
        have_held = 1'b1;
    endfunction

    // Every LF leaves as CR LF.
    function automatic void emit_text(input logic [7:0] b);
        if (b == CH_LF)
            emit_raw(CH_CR);
        emit_raw(b);
    endfunction

    // Send the buffered word, breaking the line first if it would overrun.
    function automatic void flush_word();
        if (word_nbytes != 0) begin
            if (column > 0 && column + word_cols > width_cfg) begin
                emit_text(CH_LF);
                column = 0;
            end
            for (int i = 0; i < word_nbytes; i++)
                emit_raw(word_buf[i]);
            column += word_cols;
            if (column > 255)
                column = 255;
            word_nbytes = 0;
            word_cols = 0;
        end
    endfunction

    function automatic void format_byte(input logic [7:0] c);
        logic cont;
        cont = (c[7:6] == UTF8_CONT_TAG);
        if (esc_phase != PH_NONE) begin
            // Escape bytes pass through; a final byte ends the sequence.
            emit_text(c);
            if (esc_phase == PH_ESC && c == CH_CSI)
                esc_phase = PH_CSI;
            else if (c >= ESC_FINAL_LO && c <= ESC_FINAL_HI)
                esc_phase = PH_NONE;
        end else if (c == CH_ESC) begin
            flush_word();
            esc_phase = PH_ESC;
            emit_text(c);
        end else if (c == CH_LF || c == CH_CR) begin
            flush_word();
            emit_text(c);
            column = 0;
        end else if (c == CH_SPACE) begin
            // A space at or past the width turns into a line break.
            flush_word();
            if (column >= width_cfg) begin
                emit_text(CH_LF);
                column = 0;
            end else begin
                emit_text(CH_SPACE);
                if (column < 255)
                    column++;
            end
        end else begin
            // Ordinary word byte; break long words and full buffers.
            if (!cont && word_cols >= width_cfg)
                flush_word();
            if (word_nbytes >= WORD_BUF_BYTES - 1)
                flush_word();
            word_buf[word_nbytes] = c;
            word_nbytes++;
            if (!cont)
                word_cols++;
        end
    endfunction

    function automatic void check_output(input logic [7:0] data, input logic last);
        t_tx_byte want;
        if (due_bytes.size() == 0) begin
            err_count++;
            if (err_count <= 100)
                $display("%0t: expected no output, got byte 8'h%02h tlast %0b",
                         $time, data, last);
        end else begin
            want = due_bytes.pop_front();
            if (want.data !== data || want.last !== last) begin
                err_count++;
                if (err_count <= 100)
                    $display("%0t: expected byte 8'h%02h tlast %0b, got byte 8'h%02h tlast %0b",
                             $time, want.data, want.last, data, last);
            end else begin
                ok_count++;
            end
        end
    endfunction

    // Sample every channel at the clock edge where the block sees it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_cfg = TERM_WIDTH_RST;
            discard_cfg = 1'b0;
            esc_phase = PH_NONE;
            column = 0;
            word_nbytes = 0;
            word_cols = 0;
            have_held = 1'b0;
            due_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_TERM_WIDTH: width_cfg = i_cfg_data;
                    CFG_IDX_DISCARD:    discard_cfg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready && !discard_cfg) begin
                format_byte(i_req_data);
                if (i_req_last)
                    flush_word();
                if (have_held) begin
                    held.last = 1'b1;
                    due_bytes.push_back(held);
                    have_held = 1'b0;
                end
            end
            if (i_out_valid && i_out_ready)
                check_output(i_out_data, i_out_last);
        end
        o_pending <= due_bytes.size();
        o_errors <= err_count;
        o_checked <= ok_count;
    end

endmodule

@@ tb/console_word_wrap_formatter_test.sv @@
`timescale 1ns / 100ps

module console_word_wrap_formatter_test;
    import cwwf_pkg::*;

    localparam int WORD_BUF_BYTES = 32;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [7:0] PRINT_LO = 8'h21;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = 8'd0;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_index = 8'd0;
    logic [7:0] cfg_data = 8'd0;
    logic       quiet = 1'b0;
    int         hold_req = 0;
    int         n_sent = 0;

    wire        o_s_axis_tready;
    wire        o_m_axis_tvalid;
    wire  [7:0] o_m_axis_tdata;
    wire        o_m_axis_tlast;
    wire        o_cfg_ready;
    int         pending;
    int         errors;
    int         checked;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    console_word_wrap_formatter #(
        .WORD_BUF_BYTES(WORD_BUF_BYTES)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    wrap_output_checker #(
        .WORD_BUF_BYTES(WORD_BUF_BYTES)
    ) u_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(s_valid),
        .i_req_ready(o_s_axis_tready),
        .i_req_data (s_data),
        .i_req_last (s_last),
        .i_out_valid(o_m_axis_tvalid),
        .i_out_ready(m_ready),
        .i_out_data (o_m_axis_tdata),
        .i_out_last (o_m_axis_tlast),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_errors   (errors),
        .o_checked  (checked)
    );

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Offer one text byte and wait for its request to be taken.
    task automatic send_byte(input logic [7:0] b, input logic eoc);
        s_valid <= 1'b1;
        s_data <= b;
        s_last <= eoc;
        @(posedge clk);
        while (!o_s_axis_tready)
            @(posedge clk);
        n_sent++;
        if (!quiet && chance(14)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted byte has been delivered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] wrap_at, input logic discard);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_TERM_WIDTH;
        cfg_data <= wrap_at;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_IDX_DISCARD;
        cfg_data <= {7'd0, discard};
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A word of printable and multi-byte UTF-8 characters, then mostly a separator.
    task automatic send_word(input int max_len);
        int len;
        len = chance(10) ? $urandom_range(1, max_len)
                         : $urandom_range(1, (max_len < 8) ? max_len : 8);
        repeat (len) begin
            if (chance(12)) begin
                if (chance(50)) begin
                    send_byte(8'($urandom_range(8'hC2, 8'hDF)), chance(4));
                end else begin
                    send_byte(8'($urandom_range(8'hE0, 8'hEF)), chance(4));
                    send_byte(8'($urandom_range(8'h80, 8'hBF)), chance(4));
                end
                send_byte(8'($urandom_range(8'h80, 8'hBF)), chance(4));
            end else begin
                send_byte(8'($urandom_range(PRINT_LO, PRINT_HI)), chance(4));
            end
        end
        case ($urandom_range(0, 9))
            0: send_byte(CH_LF, chance(10));
            1: send_byte(CH_CR, chance(10));
            2: ;
            default: send_byte(CH_SPACE, chance(6));
        endcase
    endtask

    // A CSI sequence with up to four parameter bytes, or a short escape of two or three bytes.
    task automatic send_escape();
        send_byte(CH_ESC, chance(5));
        if (chance(70)) begin
            send_byte(CH_CSI, chance(5));
            repeat ($urandom_range(0, 4))
                send_byte(chance(8) ? CH_LF : 8'($urandom_range(8'h30, 8'h3F)), chance(5));
        end else if (chance(30)) begin
            send_byte(8'($urandom_range(8'h20, 8'h2F)), 1'b0);
        end
        send_byte(8'($urandom_range(ESC_FINAL_LO, ESC_FINAL_HI)), chance(10));
    endtask

    // Mostly well-formed text; the rest is raw noise over all byte values.
    task automatic run_random(input int count, input int max_len);
        int stop_at;
        int pick;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                send_word(max_len);
            else if (pick < 74)
                send_escape();
            else if (pick < 82)
                repeat ($urandom_range(1, 4)) send_byte(CH_SPACE, chance(5));
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), chance(15));
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, quiet stretch.
    initial begin
        int holds_seen;
        holds_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_req != holds_seen) begin
                holds_seen = hold_req;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_ready <= quiet || !chance(14);
            end
        end
    end

    initial begin
        logic [7:0] mid_width;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset width: plain word, UTF-8 character, control bytes as word bytes.
        send_byte("H", 1'b0);
        send_byte("i", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        // Line ends.
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        // CSI sequence ended by its final byte.
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_CSI, 1'b0);
        send_byte("3", 1'b0);
        send_byte("1", 1'b0);
        send_byte("m", 1'b0);
        // Short escape with an LF inside it.
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte("c", 1'b0);
        // Escape start flushes a pending word; continuation byte in escape body.
        send_byte("x", 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte("A", 1'b0);
        send_byte("z", 1'b1);

        // Narrowest width: words break per character, a space becomes a break.
        apply_settings(8'd1, 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte("c", 1'b1);

        // Default width with a long output stall while text keeps coming.
        apply_settings(TERM_WIDTH_RST, 1'b0);
        hold_req <= hold_req + 1;
        run_random(50, 12);
        wait_drained();

        // No idling on either side for a while.
        quiet <= 1'b1;
        run_random(40, 12);
        quiet <= 1'b0;

        // Widest lines; long words also fill the word buffer.
        apply_settings(8'd255, 1'b0);
        run_random(50, 40);

        apply_settings(8'd1, 1'b0);
        run_random(35, 6);

        // Discarded text must leave no trace in the following output.
        mid_width = 8'($urandom_range(2, 40));
        apply_settings(mid_width, 1'b1);
        run_random(15, 12);
        apply_settings(mid_width, 1'b0);
        run_random(40, 12);

        apply_settings(8'($urandom_range(41, 254)), 1'b0);
        run_random(25, 20);

        wait_drained();
        if (pending != 0)
            $display("%0d expected output bytes never arrived", pending);
        $display("Sent %0d text bytes and checked %0d output bytes at widths 1, 110, 255",
                 n_sent, checked);
        $display("and two random widths, with UTF-8, escapes, line ends and discard mode.");
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
